/* hdl/trpc_pkg.sv */
// trpc_pkg: shared types and constants for the throttle ramp pwm controller
// payload structs, register indexes, reset values and fixed duties
// no dependencies
package trpc_pkg;

  // default sizing of the pwm time base and period counter
  localparam int TRPC_PWM_STEPS = 100;
  localparam int TRPC_TICK_BITS = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TAKEOFF_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOWUP_PERIOD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOWDOWN_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_DUTY       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_DUTY        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOVER_HOLD      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_MAN_DUTY   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_MAN_LIMIT  = 3'd7;

  // register reset values
  localparam logic [15:0] RST_TAKEOFF_PERIOD  = 16'd4000;
  localparam logic [15:0] RST_SLOWUP_PERIOD   = 16'd33333;
  localparam logic [15:0] RST_SLOWDOWN_PERIOD = 16'd33333;
  localparam logic [6:0]  RST_HIGH_DUTY       = 7'd60;
  localparam logic [6:0]  RST_LOW_DUTY        = 7'd37;
  localparam logic [15:0] RST_HOVER_HOLD      = 16'd10;
  localparam logic [6:0]  RST_DEAD_MAN_DUTY   = 7'd57;
  localparam logic [7:0]  RST_DEAD_MAN_LIMIT  = 8'd10;

  // fixed duties
  localparam logic [6:0] FORCED_DUTY    = 7'd37;
  localparam logic [6:0] ELEV_FWD_DUTY  = 7'd48;
  localparam logic [6:0] ELEV_BACK_DUTY = 7'd50;
  localparam logic [6:0] ELEV_MID_DUTY  = 7'd49;
  localparam logic [6:0] AIL_FIRST_DUTY = 7'd49;
  localparam logic [6:0] AIL_SEC_DUTY   = 7'd47;
  localparam logic [6:0] AIL_MID_DUTY   = 7'd48;
  localparam logic [7:0] DM_SATURATE    = 8'd255;

  // input item: one tick with the switch bits
  typedef struct packed {
    logic throttle_request;
    logic elevator_forward;
    logic elevator_back;
    logic aileron_first;
    logic aileron_second;
  } trpc_in_t;

  // result item: pin levels and throttle status after the tick
  typedef struct packed {
    logic       throttle_pwm;
    logic       aileron_pwm;
    logic       elevator_pwm;
    logic [6:0] throttle_duty_now;
    logic [1:0] mode_now;
  } trpc_out_t;

endpackage

/* hdl/throttle_ramp_pwm_controller.sv */
// throttle_ramp_pwm_controller: throttle mode machine, ramp, dead-man cutoff
// and shared-phase pwm for throttle, aileron and elevator pins
// depends on trpc_pkg
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in_     | input     | in_valid/in_stall  | trpc_in_t, one tick
//  out_    | output    | out_valid/out_stall| trpc_out_t, one per tick
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one tick per cycle while in_stall is low; each tick's result is in the output
// register in the cycle after its transfer, all state updated by one pass of compare logic
// in_stall follows out_stall only while a result is held in the output
// register; cfg_ready is always high
// synchronous active-low reset restores the register defaults and idle state
module throttle_ramp_pwm_controller
  import trpc_pkg::*;
#(
  parameter int PWM_STEPS = TRPC_PWM_STEPS,
  parameter int TICK_BITS = TRPC_TICK_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  trpc_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output trpc_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PH_W  = $clog2(PWM_STEPS + 1);
  localparam int CMP_W = (PH_W > 7) ? PH_W : 7;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(PWM_STEPS);

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_TAKEOFF  = 2'd1,
    MODE_SLOWUP   = 2'd2,
    MODE_SLOWDOWN = 2'd3
  } mode_t;

  // configuration registers
  logic [15:0] takeoff_period_r, slowup_period_r, slowdown_period_r, hover_hold_r;
  logic [6:0]  high_duty_r, low_duty_r, dead_man_duty_r;
  logic [7:0]  dead_man_limit_r;

  // block state
  mode_t                mode_r, mode_nxt;
  logic [TICK_BITS-1:0] ticks_r, ticks_nxt;
  logic [15:0]          hold_r, hold_nxt;
  logic [7:0]           dm_r, dm_nxt;
  logic [6:0]           duty_r, duty_nxt;
  logic [PH_W-1:0]      phase_r, phase_nxt;

  // output register
  logic      out_valid_r;
  trpc_out_t out_data_r, out_data_nxt;

  // combinational helpers
  logic                  in_xfer;
  logic [15:0]           period_sel;
  logic [TICK_BITS+15:0] period_ext;
  logic [TICK_BITS-1:0]  period_cmp, ticks_inc;
  logic                  period_done;
  logic [15:0]           hold_inc;
  logic [6:0]            duty_ramp, elev_duty, ail_duty;
  logic [PH_W-1:0]       phase_inc;
  logic                  t_pin, a_pin, e_pin;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // period counter against the register of the active mode
  always_comb begin
    case (mode_r)
      MODE_TAKEOFF:  period_sel = takeoff_period_r;
      MODE_SLOWUP:   period_sel = slowup_period_r;
      MODE_SLOWDOWN: period_sel = slowdown_period_r;
      default:       period_sel = takeoff_period_r;
    endcase
  end

  assign period_ext  = {{TICK_BITS{1'b0}}, period_sel};
  assign period_cmp  = period_ext[TICK_BITS-1:0];
  assign ticks_inc   = ticks_r + 1'b1;
  assign period_done = (ticks_inc == period_cmp);
  assign hold_inc    = hold_r + 16'd1;
  assign duty_ramp   = (duty_r < high_duty_r) ? duty_r + 7'd1 : duty_r;

  // throttle mode machine and dead-man cutoff
  always_comb begin
    mode_nxt  = mode_r;
    ticks_nxt = ticks_r;
    hold_nxt  = hold_r;
    dm_nxt    = dm_r;
    duty_nxt  = duty_r;
    if (mode_r != MODE_IDLE) begin
      ticks_nxt = period_done ? '0 : ticks_inc;
    end
    case (mode_r)
      MODE_IDLE: begin
        if (in_data.throttle_request) mode_nxt = MODE_TAKEOFF;
      end
      MODE_TAKEOFF: begin
        if (period_done) begin
          if (duty_r < high_duty_r) begin
            duty_nxt = duty_r + 7'd1;
          end else if (hold_inc > hover_hold_r) begin
            hold_nxt = '0;
            mode_nxt = MODE_SLOWUP;
          end else begin
            hold_nxt = hold_inc;
          end
        end
      end
      MODE_SLOWUP: begin
        if (period_done) begin
          duty_nxt = duty_ramp;
          if (duty_ramp == dead_man_duty_r) begin
            if (dm_r != DM_SATURATE) dm_nxt = dm_r + 8'd1;
          end else begin
            dm_nxt = '0;
          end
        end
        if (!in_data.throttle_request) mode_nxt = MODE_SLOWDOWN;
      end
      MODE_SLOWDOWN: begin
        if (period_done) begin
          if (duty_r >= low_duty_r && duty_r != 7'd0) duty_nxt = duty_r - 7'd1;
          else mode_nxt = MODE_IDLE;
        end
        if (in_data.throttle_request) mode_nxt = MODE_SLOWUP;
      end
      default: mode_nxt = MODE_IDLE;
    endcase
    // pins use the duty before this override, the forced duty is applied at the registers
    if (dm_nxt > dead_man_limit_r) begin
      mode_nxt = MODE_IDLE;
    end
  end

  // surface duties from switch pairs
  assign elev_duty = in_data.elevator_forward ? ELEV_FWD_DUTY :
                     (in_data.elevator_back ? ELEV_BACK_DUTY : ELEV_MID_DUTY);
  assign ail_duty  = in_data.aileron_first ? AIL_FIRST_DUTY :
                     (in_data.aileron_second ? AIL_SEC_DUTY : AIL_MID_DUTY);

  // shared pwm phase and pin compares
  assign phase_inc = phase_r + 1'b1;
  assign phase_nxt = (phase_inc >= PH_LAST) ? '0 : phase_inc;
  assign t_pin = CMP_W'(phase_inc) <= CMP_W'(duty_nxt);
  assign a_pin = CMP_W'(phase_inc) <= CMP_W'(ail_duty);
  assign e_pin = CMP_W'(phase_inc) <= CMP_W'(elev_duty);

  always_comb begin
    out_data_nxt                   = out_data_r;
    out_data_nxt.throttle_pwm      = t_pin;
    out_data_nxt.aileron_pwm       = a_pin;
    out_data_nxt.elevator_pwm      = e_pin;
    out_data_nxt.throttle_duty_now = (dm_nxt > dead_man_limit_r) ? FORCED_DUTY : duty_nxt;
    out_data_nxt.mode_now          = mode_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      takeoff_period_r  <= RST_TAKEOFF_PERIOD;
      slowup_period_r   <= RST_SLOWUP_PERIOD;
      slowdown_period_r <= RST_SLOWDOWN_PERIOD;
      high_duty_r       <= RST_HIGH_DUTY;
      low_duty_r        <= RST_LOW_DUTY;
      hover_hold_r      <= RST_HOVER_HOLD;
      dead_man_duty_r   <= RST_DEAD_MAN_DUTY;
      dead_man_limit_r  <= RST_DEAD_MAN_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TAKEOFF_PERIOD:  takeoff_period_r  <= cfg_data;
        CFG_SLOWUP_PERIOD:   slowup_period_r   <= cfg_data;
        CFG_SLOWDOWN_PERIOD: slowdown_period_r <= cfg_data;
        CFG_HIGH_DUTY:       high_duty_r       <= cfg_data[6:0];
        CFG_LOW_DUTY:        low_duty_r        <= cfg_data[6:0];
        CFG_HOVER_HOLD:      hover_hold_r      <= cfg_data;
        CFG_DEAD_MAN_DUTY:   dead_man_duty_r   <= cfg_data[6:0];
        CFG_DEAD_MAN_LIMIT:  dead_man_limit_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // state advance on each tick transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      ticks_r <= '0;
      hold_r  <= '0;
      dm_r    <= '0;
      duty_r  <= FORCED_DUTY;
      phase_r <= '0;
    end else if (in_xfer) begin
      mode_r  <= mode_nxt;
      ticks_r <= ticks_nxt;
      hold_r  <= hold_nxt;
      dm_r    <= dm_nxt;
      duty_r  <= (dm_nxt > dead_man_limit_r) ? FORCED_DUTY : duty_nxt;
      phase_r <= phase_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) out_data_r <= out_data_nxt;
  end

endmodule
